// ----- src/tlbc_pkg.sv -----
// Shared types and constants for the TLB and direct-mapped cache access path.
// Used by the front, queue, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none
package tlbc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [1:0] MODE_TLB_ONLY = 2'd0;
    localparam logic [1:0] MODE_CACHE_ONLY = 2'd1;
    localparam logic [1:0] MODE_TLB_THEN_CACHE = 2'd2;
    localparam logic [2:0] REG_HIERARCHY_MODE = 3'd0;
    localparam logic [2:0] REG_LARGE_PAGES = 3'd1;
    localparam logic [2:0] REG_TLB_SIXTEEN = 3'd2;
    localparam logic [2:0] REG_CACHE_LARGE = 3'd3;
    localparam logic [2:0] REG_BLOCK_SIXTYFOUR = 3'd4;
    localparam logic [23:0] SMALL_PAGE_MASK = 24'hFFF0FF;
    localparam logic [23:0] LARGE_PAGE_MASK = 24'h0FFF0F;

    typedef struct packed {
        logic [1:0] hierarchy_mode;
        logic       large_pages;
        logic       tlb_sixteen;
        logic       cache_large;
        logic       block_sixtyfour;
    } t_cfg;

    typedef struct packed {
        logic        tlb_checked;
        logic        tlb_hit;
        logic        cache_checked;
        logic        page_walk;
        logic [31:0] physical_address;
    } t_job;

endpackage
`default_nettype wire

// ----- src/tlb_lru_with_direct_mapped_cache_core.sv -----
// Top level of the TLB and direct-mapped cache access path: configuration
// registers, front end, item queue and back end. Uses tlbc_pkg.
//
// An access is taken when start is high and busy is low; its result appears
// one cycle wide on the o_ ports, marked by o_result_valid, and cannot be held
// off. The front end captures an access, then does the parallel TLB compare and
// LRU update, which waits while the queue is full; the back end reads the cache tag
// memory, then does the compare and fill. The front end takes no new access until
// it has pushed the last one into the queue. After reset the cache tag memory is
// cleared one block per cycle, during which busy stays high.
`timescale 1ns / 1ps
`default_nettype none
module tlb_lru_with_direct_mapped_cache_core #(
    parameter int TLB_MAX_ENTRIES = 16,
    parameter int CACHE_MAX_BLOCKS = 2048
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    input  wire          i_is_data,
    input  wire  [31:0]  i_virtual_address,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [1:0]   i_cfg_data,
    output logic         o_result_valid,
    output logic         o_tlb_checked,
    output logic         o_tlb_hit,
    output logic         o_cache_checked,
    output logic         o_cache_hit,
    output logic         o_page_walk,
    output logic [31:0]  o_physical_address
);
    import tlbc_pkg::*;

    t_cfg  r_cfg;
    t_job  push_job;
    t_job  head;
    logic  front_busy;
    logic  clearing;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;

    assign o_cfg_ready = 1'b1;
    assign busy = front_busy || clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hierarchy_mode <= MODE_TLB_THEN_CACHE;
            r_cfg.large_pages <= 1'b0;
            r_cfg.tlb_sixteen <= 1'b1;
            r_cfg.cache_large <= 1'b0;
            r_cfg.block_sixtyfour <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HIERARCHY_MODE:  r_cfg.hierarchy_mode <= i_cfg_data;
                REG_LARGE_PAGES:     r_cfg.large_pages <= i_cfg_data[0];
                REG_TLB_SIXTEEN:     r_cfg.tlb_sixteen <= i_cfg_data[0];
                REG_CACHE_LARGE:     r_cfg.cache_large <= i_cfg_data[0];
                REG_BLOCK_SIXTYFOUR: r_cfg.block_sixtyfour <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tlbc_front #(
        .TLB_MAX_ENTRIES(TLB_MAX_ENTRIES)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_start(start && !busy),
        .i_is_data(i_is_data),
        .i_virtual_address(i_virtual_address),
        .o_busy(front_busy),
        .i_queue_full(q_full),
        .o_push(push),
        .o_job(push_job)
    );

    tlbc_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_job(push_job),
        .o_full(q_full),
        .i_pop(pop),
        .o_head(head),
        .o_empty(q_empty)
    );

    tlbc_back #(
        .CACHE_MAX_BLOCKS(CACHE_MAX_BLOCKS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_head(head),
        .i_empty(q_empty),
        .o_pop(pop),
        .o_clearing(clearing),
        .o_result_valid(o_result_valid),
        .o_tlb_checked(o_tlb_checked),
        .o_tlb_hit(o_tlb_hit),
        .o_cache_checked(o_cache_checked),
        .o_cache_hit(o_cache_hit),
        .o_page_walk(o_page_walk),
        .o_physical_address(o_physical_address)
    );

endmodule
`default_nettype wire

// ----- src/tlbc_front.sv -----
// Front end: accepts an access, looks it up in the fully associative TLB with
// true-LRU replacement and pushes the translated item into the queue. Uses tlbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlbc_front #(
    parameter int TLB_MAX_ENTRIES = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tlbc_pkg::t_cfg    i_cfg,
    input  wire               i_start,
    input  wire               i_is_data,
    input  wire  [31:0]       i_virtual_address,
    output logic              o_busy,
    input  wire               i_queue_full,
    output logic              o_push,
    output tlbc_pkg::t_job    o_job
);
    import tlbc_pkg::*;

    localparam int TIW = $clog2(TLB_MAX_ENTRIES);
    localparam int AW = TIW + 1;

    typedef enum logic {S_IDLE, S_LOOK} t_state;

    t_state               r_state;
    logic [31:0]          r_va;
    logic                 r_is_data;
    logic                 r_valid [TLB_MAX_ENTRIES];
    logic [23:0]          r_tag   [TLB_MAX_ENTRIES];
    logic [23:0]          r_frame [TLB_MAX_ENTRIES];
    logic [TIW-1:0]       r_rank  [TLB_MAX_ENTRIES];

    logic [AW-1:0]        active;
    logic [23:0]          vpn;
    logic [23:0]          frame_new;
    logic [23:0]          ppn;
    logic                 use_tlb;
    logic                 hit;
    logic [TIW-1:0]       hit_idx;
    logic [TIW-1:0]       vic_idx;
    logic [TIW-1:0]       slot;
    logic [TIW-1:0]       slot_rank;
    logic [TLB_MAX_ENTRIES-1:0] match;
    logic [TLB_MAX_ENTRIES-1:0] vic;
    logic                 fire;

    always_comb begin
        active = i_cfg.tlb_sixteen ? AW'(TLB_MAX_ENTRIES) : AW'(8);
        vpn = i_cfg.large_pages ? {4'b0, r_va[31:12]} : r_va[31:8];
        frame_new = ~vpn & (i_cfg.large_pages ? LARGE_PAGE_MASK : SMALL_PAGE_MASK);
        use_tlb = (i_cfg.hierarchy_mode != MODE_CACHE_ONLY);
        for (int i = 0; i < TLB_MAX_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_tag[i] == vpn) && (AW'(i) < active);
            vic[i] = (AW'(i) < active);
            for (int j = 0; j < TLB_MAX_ENTRIES; j++) begin
                if (AW'(j) < active) begin
                    if (j < i && !(r_rank[j] > r_rank[i])) begin
                        vic[i] = 1'b0;
                    end
                    if (j > i && !(r_rank[j] >= r_rank[i])) begin
                        vic[i] = 1'b0;
                    end
                end
            end
        end
        hit = |match;
        hit_idx = '0;
        vic_idx = '0;
        for (int i = TLB_MAX_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = TIW'(i);
            end
            if (vic[i]) begin
                vic_idx = TIW'(i);
            end
        end
        slot = hit ? hit_idx : vic_idx;
        slot_rank = r_rank[slot];
        ppn = (use_tlb && hit) ? r_frame[hit_idx] : frame_new;
        fire = (r_state == S_LOOK) && !i_queue_full;
        o_push = fire;
        o_job.tlb_checked = use_tlb;
        o_job.tlb_hit = use_tlb && hit;
        o_job.cache_checked = (i_cfg.hierarchy_mode != MODE_TLB_ONLY);
        o_job.page_walk = !use_tlb || !hit;
        o_job.physical_address = i_cfg.large_pages ? {ppn[19:0], r_va[11:0]}
                                                   : {ppn, r_va[7:0]};
        o_busy = (r_state != S_IDLE) || r_is_data && 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < TLB_MAX_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i] <= TIW'(i);
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_va <= i_virtual_address;
                        r_is_data <= i_is_data;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (fire) begin
                        r_state <= S_IDLE;
                        if (use_tlb) begin
                            if (!hit) begin
                                r_valid[slot] <= 1'b1;
                                r_tag[slot] <= vpn;
                                r_frame[slot] <= frame_new;
                            end
                            for (int i = 0; i < TLB_MAX_ENTRIES; i++) begin
                                if (AW'(i) < active && r_rank[i] > slot_rank) begin
                                    r_rank[i] <= r_rank[i] - 1'b1;
                                end
                            end
                            r_rank[slot] <= TIW'(active - 1'b1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/tlbc_queue.sv -----
// Short item queue between the TLB front end and the cache back end.
// Uses tlbc_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none
module tlbc_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  tlbc_pkg::t_job    i_job,
    output logic              o_full,
    input  wire               i_pop,
    output tlbc_pkg::t_job    o_head,
    output logic              o_empty
);
    import tlbc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;

    assign o_full = (r_cnt == (PW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW + 1)'(i_push) - (PW + 1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ----- src/tlbc_back.sv -----
// Back end: clears the cache tag memory after reset, then reads the direct-mapped
// cache per item, fills it on a miss if checked, emits the result. Uses tlbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlbc_back #(
    parameter int CACHE_MAX_BLOCKS = 2048
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tlbc_pkg::t_cfg    i_cfg,
    input  tlbc_pkg::t_job    i_head,
    input  wire               i_empty,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_result_valid,
    output logic              o_tlb_checked,
    output logic              o_tlb_hit,
    output logic              o_cache_checked,
    output logic              o_cache_hit,
    output logic              o_page_walk,
    output logic [31:0]       o_physical_address
);
    import tlbc_pkg::*;

    localparam int CIW = $clog2(CACHE_MAX_BLOCKS);

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_CHECK} t_state;

    t_state           r_state;
    logic [CIW-1:0]   r_clr;
    t_job             r_job;
    logic [CIW-1:0]   r_idx;
    logic [18:0]      r_tag;
    logic [19:0]      r_rd;
    logic [19:0]      r_mem [CACHE_MAX_BLOCKS];

    logic [10:0]      idx_raw;
    logic [CIW-1:0]   idx;
    logic [18:0]      tag;
    logic             hit;
    logic             we;
    logic [CIW-1:0]   waddr;
    logic [19:0]      wdata;

    always_comb begin
        idx_raw = i_cfg.block_sixtyfour ? i_head.physical_address[16:6]
                                        : i_head.physical_address[15:5];
        if (!i_cfg.cache_large) begin
            idx_raw[10:8] = 3'b0;
        end
        idx = idx_raw[CIW-1:0];
        case ({i_cfg.cache_large, i_cfg.block_sixtyfour})
            2'b00: tag = i_head.physical_address[31:13];
            2'b01: tag = {1'b0, i_head.physical_address[31:14]};
            2'b10: tag = {3'b0, i_head.physical_address[31:16]};
            default: tag = {4'b0, i_head.physical_address[31:17]};
        endcase
        o_pop = (r_state == B_IDLE) && !i_empty;
        o_clearing = (r_state == B_CLEAR);
        hit = r_job.cache_checked && r_rd[19] && (r_rd[18:0] == r_tag);
        if (r_state == B_CLEAR) begin
            we = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else begin
            we = (r_state == B_CHECK) && r_job.cache_checked && !hit;
            waddr = r_idx;
            wdata = {1'b1, r_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CIW'(CACHE_MAX_BLOCKS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_head;
                        r_idx <= idx;
                        r_tag <= tag;
                        r_state <= B_CHECK;
                    end
                end
                B_CHECK: begin
                    o_result_valid <= 1'b1;
                    o_tlb_checked <= r_job.tlb_checked;
                    o_tlb_hit <= r_job.tlb_hit;
                    o_cache_checked <= r_job.cache_checked;
                    o_cache_hit <= hit;
                    o_page_walk <= r_job.page_walk;
                    o_physical_address <= r_job.physical_address;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- verif/tlb_lru_with_direct_mapped_cache_core_tb.sv -----
// Testbench for the TLB and direct-mapped cache access path. It predicts every
// access result and compares it field by field with the block's output.
// Depends on tlbc_pkg and tlb_lru_with_direct_mapped_cache_core.
`timescale 1ns / 1ps
`default_nettype none
module tlb_lru_with_direct_mapped_cache_core_tb;
    import tlbc_pkg::*;

    typedef struct packed {
        logic        tlb_checked;
        logic        tlb_hit;
        logic        cache_checked;
        logic        cache_hit;
        logic        page_walk;
        logic [31:0] physical_address;
    } t_access_result;

    class access_path_scoreboard;
        t_cfg           cfg;
        bit             tlb_valid [16];
        logic [23:0]    tlb_tag [16];
        logic [23:0]    tlb_frame [16];
        int unsigned    tlb_rank [16];
        bit             blk_valid [2048];
        logic [18:0]    blk_tag [2048];
        t_access_result awaited [$];
        int             mismatches;
        int             checked;
        int             tlb_hits;
        int             cache_hits;

        function new();
            cfg = '{hierarchy_mode: MODE_TLB_THEN_CACHE, large_pages: 1'b0,
                    tlb_sixteen: 1'b1, cache_large: 1'b0, block_sixtyfour: 1'b0};
            for (int i = 0; i < 16; i++) begin
                tlb_valid[i] = 1'b0;
                tlb_rank[i] = i;
            end
            foreach (blk_valid[i]) blk_valid[i] = 1'b0;
        endfunction

        function void set_register(logic [2:0] idx, logic [1:0] value);
            case (idx)
                REG_HIERARCHY_MODE:  cfg.hierarchy_mode = value;
                REG_LARGE_PAGES:     cfg.large_pages = value[0];
                REG_TLB_SIXTEEN:     cfg.tlb_sixteen = value[0];
                REG_CACHE_LARGE:     cfg.cache_large = value[0];
                REG_BLOCK_SIXTYFOUR: cfg.block_sixtyfour = value[0];
                default: ;
            endcase
        endfunction

        function logic [23:0] walk_pages(logic [31:0] vpn);
            logic [31:0] inverted;
            inverted = ~vpn;
            return cfg.large_pages ? inverted[23:0] & LARGE_PAGE_MASK
                                   : inverted[23:0] & SMALL_PAGE_MASK;
        endfunction

        function void note_access(logic [31:0] va);
            t_access_result r;
            int unsigned    off, active, slot, rank, boff, ibits, idx;
            logic [31:0]    vpn, poff, ppn, pa;
            logic [18:0]    tag;
            bit             found;
            off = cfg.large_pages ? 12 : 8;
            vpn = va >> off;
            poff = va & ((32'd1 << off) - 1);
            r = '0;
            r.tlb_checked = (cfg.hierarchy_mode != MODE_CACHE_ONLY);
            r.cache_checked = (cfg.hierarchy_mode != MODE_TLB_ONLY);
            if (r.tlb_checked) begin
                active = cfg.tlb_sixteen ? 16 : 8;
                slot = 0;
                found = 1'b0;
                for (int i = 0; i < active; i++) begin
                    if (!found && tlb_valid[i] && tlb_tag[i] == vpn[23:0]) begin
                        slot = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    for (int i = 1; i < active; i++)
                        if (tlb_rank[i] < tlb_rank[slot]) slot = i;
                    tlb_valid[slot] = 1'b1;
                    tlb_tag[slot] = vpn[23:0];
                    tlb_frame[slot] = walk_pages(vpn);
                    r.page_walk = 1'b1;
                end else begin
                    r.tlb_hit = 1'b1;
                end
                rank = tlb_rank[slot];
                for (int i = 0; i < active; i++)
                    if (tlb_rank[i] > rank) tlb_rank[i] = tlb_rank[i] - 1;
                tlb_rank[slot] = (active - 1) & 4'hF;
                ppn = {8'd0, tlb_frame[slot]};
            end else begin
                ppn = {8'd0, walk_pages(vpn)};
                r.page_walk = 1'b1;
            end
            pa = (ppn << off) | poff;
            r.physical_address = pa;
            if (r.cache_checked) begin
                boff = cfg.block_sixtyfour ? 6 : 5;
                ibits = cfg.cache_large ? 11 : 8;
                idx = (pa >> boff) & ((1 << ibits) - 1);
                tag = 19'((pa >> (boff + ibits)) & 32'h7FFFF);
                if (blk_valid[idx] && blk_tag[idx] == tag) begin
                    r.cache_hit = 1'b1;
                end else begin
                    blk_valid[idx] = 1'b1;
                    blk_tag[idx] = tag;
                end
            end
            tlb_hits += int'(r.tlb_hit);
            cache_hits += int'(r.cache_hit);
            awaited.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(t_access_result got);
            t_access_result want;
            checked++;
            if (awaited.size() == 0) begin
                report("result with no access outstanding");
                return;
            end
            want = awaited.pop_front();
            if (got.tlb_checked !== want.tlb_checked) report("tlb_checked");
            if (got.tlb_hit !== want.tlb_hit) report("tlb_hit");
            if (got.cache_checked !== want.cache_checked) report("cache_checked");
            if (got.cache_hit !== want.cache_hit) report("cache_hit");
            if (got.page_walk !== want.page_walk) report("page_walk");
            if (got.physical_address !== want.physical_address)
                report($sformatf("physical_address got %h want %h",
                                 got.physical_address, want.physical_address));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_is_data;
    logic [31:0] i_virtual_address;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [1:0]  i_cfg_data;
    logic        o_result_valid;
    logic        o_tlb_checked;
    logic        o_tlb_hit;
    logic        o_cache_checked;
    logic        o_cache_hit;
    logic        o_page_walk;
    logic [31:0] o_physical_address;

    access_path_scoreboard sb = new();
    int          accesses_taken;
    int          writes_taken;
    bit          allow_idle;
    logic [23:0] page_pool [24];

    tlb_lru_with_direct_mapped_cache_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_is_data(i_is_data), .i_virtual_address(i_virtual_address),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid), .o_tlb_checked(o_tlb_checked),
        .o_tlb_hit(o_tlb_hit), .o_cache_checked(o_cache_checked),
        .o_cache_hit(o_cache_hit), .o_page_walk(o_page_walk),
        .o_physical_address(o_physical_address)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_register(i_cfg_index, i_cfg_data);
                writes_taken <= writes_taken + 1;
            end
            if (start && !busy) begin
                sb.note_access(i_virtual_address);
                accesses_taken <= accesses_taken + 1;
            end
            if (o_result_valid)
                sb.check_result('{o_tlb_checked, o_tlb_hit, o_cache_checked,
                                  o_cache_hit, o_page_walk, o_physical_address});
        end
    end

    task automatic write_register(input logic [2:0] idx, input logic [1:0] value);
        int n;
        n = writes_taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        wait (writes_taken != n);
    endtask

    task automatic configure(input logic [1:0] mode, input bit lp, input bit t16,
                             input bit cl, input bit b64);
        wait (sb.awaited.size() == 0);
        repeat (10) @(posedge i_clk);
        write_register(REG_HIERARCHY_MODE, mode);
        write_register(REG_LARGE_PAGES, {1'b0, lp});
        write_register(REG_TLB_SIXTEEN, {1'b0, t16});
        write_register(REG_CACHE_LARGE, {1'b0, cl});
        write_register(REG_BLOCK_SIXTYFOUR, {1'b0, b64});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_access(input bit kind, input logic [31:0] va);
        int n;
        n = accesses_taken;
        start <= 1'b1;
        i_is_data <= kind;
        i_virtual_address <= va;
        wait (accesses_taken != n);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic random_accesses(input int count);
        logic [31:0] va;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 6) == 0)
                va = $urandom();
            else
                va = {page_pool[$urandom_range(0, 23)], 8'(($urandom_range(0, 255)))};
            send_access(1'($urandom_range(0, 1)), va);
        end
        start <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_is_data = 1'b0;
        i_virtual_address = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        accesses_taken = 0;
        writes_taken = 0;
        allow_idle = 1'b1;
        foreach (page_pool[i]) page_pool[i] = 24'($urandom());
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b1, 32'hFFFF_FF00);
        send_access(1'b0, 32'h0000_00FF);
        for (int i = 0; i < 18; i++) send_access(i[0], {i[7:0], 24'h00_0040});
        send_access(1'b1, 32'h0000_0010);
        start <= 1'b0;

        configure(MODE_TLB_THEN_CACHE, 1'b0, 1'b1, 1'b0, 1'b0);
        random_accesses(160);
        configure(MODE_TLB_ONLY, 1'b1, 1'b0, 1'b1, 1'b1);
        random_accesses(160);
        configure(MODE_CACHE_ONLY, 1'b0, 1'b0, 1'b1, 1'b0);
        random_accesses(160);
        configure(2'd3, 1'b1, 1'b1, 1'b0, 1'b1);
        random_accesses(160);
        foreach (page_pool[i]) if (i[0]) page_pool[i] = 24'($urandom());
        configure(MODE_TLB_THEN_CACHE, 1'b0, 1'b0, 1'b1, 1'b1);
        random_accesses(160);
        configure(MODE_TLB_ONLY, 1'b0, 1'b1, 1'b0, 1'b0);
        random_accesses(160);
        allow_idle = 1'b0;
        configure(MODE_TLB_THEN_CACHE, 1'b1, 1'b1, 1'b1, 1'b0);
        random_accesses(200);

        wait (sb.awaited.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Checked %0d results over seven register settings and all hierarchy modes.",
                 sb.checked);
        $display("Predicted %0d TLB hits and %0d cache hits.", sb.tlb_hits, sb.cache_hits);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
